@@ sv/crc_pkg.sv @@
// ----------------------------------------------------------------------------
// Completed range coalescer package
// Shared types and constants for the range coalescer.
// ----------------------------------------------------------------------------
package crc_pkg;

   localparam int MAX_RANGES  = 64;
   localparam int OFFSET_BITS = 48;
   localparam int IDX_BITS    = $clog2(MAX_RANGES);
   localparam int CNT_BITS    = $clog2(MAX_RANGES + 1);
   localparam int ENTRY_BITS  = 2 * OFFSET_BITS;

   localparam logic CMD_COMMIT = 1'b0;
   localparam logic CMD_GAP    = 1'b1;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef logic [OFFSET_BITS-1:0] offset_type;

   typedef struct packed {
      logic       command;
      offset_type range_begin;
      offset_type range_end;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      offset_type gap_end;
      offset_type completed_length;
      offset_type contiguous_length;
      logic       is_complete;
   } rsp_type;

endpackage

@@ sv/crc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module crc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ sv/completed_range_coalescer.sv @@
// ----------------------------------------------------------------------------
// Completed range coalescer
// Sorted table of disjoint completed byte ranges with merge and gap query.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low. Busy
// then stays high while the sequencer works on the item. The single result is
// shown on rsp_data for exactly one cycle with rsp_valid high, and that is the
// first cycle in which busy is low again. The receiver cannot stall the result,
// so the next item may be taken at the edge that ends the result cycle. The
// table lives in one RAM with a registered read port and is walked one entry
// per cycle by a single comparator pair. A commit scans up to the first entry
// that ends at or after its begin. It then absorbs every entry that overlaps or
// touches it, or it shifts the entries above its slot up by one. After a merge
// it compacts the tail down, and a response state registers the result. No
// clearing pass is needed: only entries below the fill count are ever used.
// Entry 0 is mirrored in registers for the prefix and complete flags.
// total_length is written through the csr_ channel, which is ready only while
// the block is idle and no item is being offered.
// ----------------------------------------------------------------------------
module completed_range_coalescer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  crc_pkg::req_type    req_data,
   output logic                rsp_valid,
   output crc_pkg::rsp_type    rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  crc_pkg::offset_type csr_data
);
   import crc_pkg::*;

   // One-hot sequencer states.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FIND  = 6'b000010, // walk to the first entry that ends at or after begin
      ST_MERGE = 6'b000100, // absorb further overlapping or touching entries
      ST_UP    = 6'b001000, // shift entries up by one, top first, then insert
      ST_DOWN  = 6'b010000, // compact the tail down after a merge
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic                cmd_ff, cmd_in;
   offset_type          b_ff, b_in, e_ff, e_in;
   offset_type          total_ff, total_in;
   offset_type          covered_ff, covered_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] i_ff, i_in;       // merge slot, or write pointer
   logic [CNT_BITS-1:0] j_ff, j_in;       // entry whose data is on the read port
   offset_type          gap_ff, gap_in;
   logic [1:0]          status_ff, status_in;
   offset_type          first_start_ff, first_start_in;
   offset_type          first_end_ff, first_end_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   logic                  ram_we;
   logic [IDX_BITS-1:0]   ram_wa, ram_ra;
   logic [ENTRY_BITS-1:0] ram_wd, ram_rd;
   offset_type            rd_start, rd_end, rd_len;
   logic [CNT_BITS-1:0]   j_next;

   crc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_RANGES)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   assign rd_start = ram_rd[ENTRY_BITS-1:OFFSET_BITS];
   assign rd_end   = ram_rd[OFFSET_BITS-1:0];
   assign rd_len   = rd_end - rd_start;
   assign j_next   = j_ff + 1'b1;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      offset_type end_clamp;
      end_clamp      = req_data.range_end;
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      b_in           = b_ff;
      e_in           = e_ff;
      total_in       = total_ff;
      covered_in     = covered_ff;
      count_in       = count_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      gap_in         = gap_ff;
      status_in      = status_ff;
      first_start_in = first_start_ff;
      first_end_in   = first_end_ff;
      ram_we         = 1'b0;
      ram_wa         = i_ff[IDX_BITS-1:0];
      ram_wd         = {b_ff, e_ff};
      // The read port normally runs one entry ahead of the compare.
      ram_ra         = j_next[IDX_BITS-1:0];
      if (total_ff != '0 && req_data.range_end > total_ff) begin
         end_clamp = total_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            ram_ra = '0;
            if (csr_valid && csr_ready) begin
               total_in = csr_data;
            end
            if (start) begin
               cmd_in    = req_data.command;
               b_in      = req_data.range_begin;
               e_in      = (req_data.command == CMD_COMMIT) ? end_clamp
                                                             : req_data.range_end;
               gap_in    = req_data.range_end;
               status_in = STATUS_DONE;
               i_in      = '0;
               j_in      = '0;
               // The clamped end never exceeds the raw end, so one compare
               // catches both an empty range and one emptied by clamping.
               if (req_data.command == CMD_COMMIT &&
                   end_clamp <= req_data.range_begin) begin
                  status_in = STATUS_IGNORED;
                  state_in  = ST_RESP;
               end else begin
                  state_in  = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (j_ff >= count_ff) begin
               if (cmd_ff == CMD_GAP) begin
                  state_in = ST_RESP;
               end else if (count_ff >= CNT_BITS'(MAX_RANGES)) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_RESP;
               end else begin
                  // Append after the last entry; nothing has to move.
                  i_in     = count_ff;
                  j_in     = count_ff;
                  state_in = ST_UP;
               end
            end else if (cmd_ff == CMD_GAP) begin
               if (rd_start > b_ff) begin
                  if (rd_start < gap_ff) gap_in = rd_start;
                  state_in = ST_RESP;
               end else begin
                  j_in = j_next;
               end
            end else if (rd_end < b_ff) begin
               j_in = j_next;
            end else if (rd_start <= e_ff) begin
               // First overlapping or touching entry: it becomes the merge slot.
               i_in = j_ff;
               if (rd_start < b_ff) b_in = rd_start;
               if (rd_end > e_ff) e_in = rd_end;
               covered_in = covered_ff - rd_len;
               j_in       = j_next;
               state_in   = ST_MERGE;
            end else if (count_ff >= CNT_BITS'(MAX_RANGES)) begin
               status_in = STATUS_FULL;
               state_in  = ST_RESP;
            end else begin
               // Insert before this entry; start the shift with the top entry.
               i_in     = j_ff;
               j_in     = count_ff;
               ram_ra   = IDX_BITS'(count_ff - 1'b1);
               state_in = ST_UP;
            end
         end
         ST_MERGE: begin
            if (j_ff < count_ff && rd_start <= e_ff) begin
               if (rd_end > e_ff) e_in = rd_end;
               covered_in = covered_ff - rd_len;
               j_in       = j_next;
            end else begin
               // Write the merged range into its slot.
               ram_we     = 1'b1;
               covered_in = covered_ff + (e_ff - b_ff);
               if (j_ff < count_ff) begin
                  i_in     = i_ff + 1'b1;
                  ram_ra   = j_ff[IDX_BITS-1:0];
                  state_in = ST_DOWN;
               end else begin
                  count_in = i_ff + 1'b1;
                  state_in = ST_RESP;
               end
            end
         end
         ST_UP: begin
            if (j_ff == i_ff) begin
               ram_we     = 1'b1;
               covered_in = covered_ff + (e_ff - b_ff);
               count_in   = count_ff + 1'b1;
               state_in   = ST_RESP;
            end else begin
               // The read port holds entry j-1; move it to j.
               ram_we = 1'b1;
               ram_wa = j_ff[IDX_BITS-1:0];
               ram_wd = ram_rd;
               ram_ra = IDX_BITS'(j_ff - 2'd2);
               j_in   = j_ff - 1'b1;
            end
         end
         ST_DOWN: begin
            // The read port holds entry j; move it to the write pointer.
            ram_we = 1'b1;
            ram_wa = i_ff[IDX_BITS-1:0];
            ram_wd = ram_rd;
            i_in   = i_ff + 1'b1;
            j_in   = j_next;
            if (j_next >= count_ff) begin
               count_in = i_ff + 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // Keep a copy of entry 0 for the prefix and complete flags.
      if (ram_we && ram_wa == '0) begin
         first_start_in = ram_wd[ENTRY_BITS-1:OFFSET_BITS];
         first_end_in   = ram_wd[OFFSET_BITS-1:0];
      end

      rsp_in.status            = status_ff;
      rsp_in.gap_end           = (cmd_ff == CMD_GAP) ? gap_ff : '0;
      rsp_in.completed_length  = covered_ff;
      rsp_in.contiguous_length = (count_ff != '0 && first_start_ff == '0)
                                 ? first_end_ff : '0;
      rsp_in.is_complete       = (total_ff != '0 && count_ff == CNT_BITS'(1) &&
                                  first_start_ff == '0 && first_end_ff >= total_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         covered_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         covered_ff   <= covered_in;
         count_ff     <= count_in;
         rsp_valid_ff <= (state_ff == ST_RESP);
      end
      cmd_ff         <= cmd_in;
      b_ff           <= b_in;
      e_ff           <= e_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      gap_ff         <= gap_in;
      status_ff      <= status_in;
      first_start_ff <= first_start_in;
      first_end_ff   <= first_end_in;
      if (state_ff == ST_RESP) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Completed range coalescer testbench
// Drives commits and gap queries from a queue of pending items, keeps its own
// sorted range table to work out the expected result of each item, and checks
// every result, as a whole struct, against the oldest pending expectation.
// ----------------------------------------------------------------------------
module testbench;
   import crc_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   offset_type csr_data = '0;

   completed_range_coalescer dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Predictor state: the range table as the block should hold it.
   offset_type tracked_starts[$];
   offset_type tracked_ends[$];
   offset_type tracked_total;
   offset_type object_length;

   req_type pending_items[$];
   rsp_type expected_results[$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   bit      quiet_phase = 1'b0;
   int      gap_left = 0;

   // Works out the result of one item and updates the predicted table.
   function automatic rsp_type predict_range_item(req_type item);
      rsp_type    r;
      offset_type b, e;
      int         lo, hi;
      r = '0;
      b = item.range_begin;
      e = item.range_end;
      if (item.command == CMD_COMMIT) begin
         if (e <= b) begin
            r.status = STATUS_IGNORED;
         end else begin
            if (object_length != 0 && e > object_length) e = object_length;
            if (e <= b) begin
               r.status = STATUS_IGNORED;
            end else begin
               lo = 0;
               while (lo < tracked_starts.size() && tracked_ends[lo] < b) lo++;
               hi = lo;
               while (hi < tracked_starts.size() && tracked_starts[hi] <= e) hi++;
               if (hi == lo && tracked_starts.size() >= MAX_RANGES) begin
                  r.status = STATUS_FULL;
               end else begin
                  if (hi > lo) begin
                     if (tracked_starts[lo] < b) b = tracked_starts[lo];
                     if (tracked_ends[hi-1] > e) e = tracked_ends[hi-1];
                     for (int k = lo; k < hi; k++) begin
                        tracked_total -= tracked_ends[lo] - tracked_starts[lo];
                        tracked_starts.delete(lo);
                        tracked_ends.delete(lo);
                     end
                  end
                  tracked_starts.insert(lo, b);
                  tracked_ends.insert(lo, e);
                  tracked_total += e - b;
                  r.status = STATUS_DONE;
               end
            end
         end
      end else begin
         // A query answers with the first stored start beyond its begin, capped at its end.
         r.gap_end = e;
         foreach (tracked_starts[k]) begin
            if (tracked_starts[k] > b) begin
               if (tracked_starts[k] < e) r.gap_end = tracked_starts[k];
               break;
            end
         end
      end
      r.completed_length = tracked_total;
      if (tracked_starts.size() > 0 && tracked_starts[0] == 0)
         r.contiguous_length = tracked_ends[0];
      r.is_complete = object_length != 0 && tracked_starts.size() == 1 &&
                      tracked_starts[0] == 0 && tracked_ends[0] >= object_length;
      return r;
   endfunction

   // Driver: items leave the queue at falling edges; start holds until taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            if (pending_items.size() > 0 && (quiet_phase || $urandom_range(3) != 0)
                && gap_left == 0) begin
               req_data <= pending_items[0];
               expected_results.insert(expected_results.size(),
                                       predict_range_item(pending_items.pop_front()));
            end else begin
               start <= 1'b0;
               if (!quiet_phase) gap_left = $urandom_range(1, 3);
            end
         end else if (!start && pending_items.size() > 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               req_data <= pending_items[0];
               expected_results.insert(expected_results.size(),
                                       predict_range_item(pending_items.pop_front()));
               start <= 1'b1;
            end
         end
      end
   end

   // Monitor: compares each result with the oldest expectation.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %p", rsp_data);
         end else begin
            if (rsp_data !== expected_results[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected %p, actual %p",
                           expected_results[0], rsp_data);
            end
            void'(expected_results.pop_front());
         end
      end
      if (cycle_count > 2000000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic wait_until_drained();
      while (pending_items.size() > 0 || start || expected_results.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // Writes the object length while the block is idle.
   task automatic write_object_length(offset_type value);
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      object_length = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic offset_type random_offset();
      return offset_type'({$urandom(), $urandom()});
   endfunction

   task automatic queue_item(logic cmd, offset_type b, offset_type e);
      req_type item;
      item.command     = cmd;
      item.range_begin = b;
      item.range_end   = e;
      pending_items.insert(pending_items.size(), item);
   endtask

   // A phase of random items; most are well-formed commits in a window
   // scaled so that ranges both merge and stay apart.
   task automatic queue_random_phase(int count, offset_type window);
      offset_type b, len;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0: queue_item(1'($urandom_range(1)), random_offset(), random_offset());
            1, 2: queue_item(CMD_GAP, random_offset() % window, random_offset() % window);
            3: queue_item(CMD_COMMIT, random_offset() % window, random_offset() % window);
            default: begin
               b   = random_offset() % window;
               len = 1 + random_offset() % (window / 32 + 1);
               queue_item(CMD_COMMIT, b, b + len);
            end
         endcase
      end
   endtask

   localparam offset_type OFFSET_MAX = '1;

   initial begin
      tracked_total = '0;
      object_length = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: extremes, both commands, empty and reversed ranges, and merges.
      queue_item(CMD_GAP, '0, OFFSET_MAX);
      queue_item(CMD_COMMIT, 100, 100);
      queue_item(CMD_COMMIT, 200, 100);
      queue_item(CMD_COMMIT, 10, 20);
      queue_item(CMD_COMMIT, 20, 30);
      queue_item(CMD_COMMIT, 40, 50);
      queue_item(CMD_GAP, 5, 1000);
      queue_item(CMD_GAP, 45, 1000);
      queue_item(CMD_GAP, OFFSET_MAX, '0);
      queue_item(CMD_COMMIT, 0, 45);
      queue_item(CMD_COMMIT, OFFSET_MAX - 1, OFFSET_MAX);
      queue_item(CMD_COMMIT, 0, OFFSET_MAX);
      wait_until_drained();

      // Clamping and the complete flag, then a clamp that empties a range.
      write_object_length(1000);
      queue_item(CMD_COMMIT, 0, 5000);
      queue_item(CMD_COMMIT, 1000, 2000);
      queue_item(CMD_GAP, 0, 2000);
      wait_until_drained();
      write_object_length(500);
      queue_item(CMD_COMMIT, 600, 700);
      queue_item(CMD_COMMIT, 100, 200);
      wait_until_drained();
      write_object_length(OFFSET_MAX);
      queue_random_phase(200, 64'd4096);
      wait_until_drained();

      // Sparse disjoint commits fill the table so the full case is hit.
      write_object_length('0);
      for (int n = 0; n < 70; n++)
         queue_item(CMD_COMMIT, offset_type'(64'd1000000 + n*4),
                    offset_type'(64'd1000002 + n*4));
      queue_item(CMD_COMMIT, 64'd5000000, 64'd5000001);
      queue_random_phase(300, 64'd4000000);
      wait_until_drained();

      write_object_length(64'd50000);
      queue_random_phase(400, 64'd60000);
      wait_until_drained();
      write_object_length(64'd1);
      queue_random_phase(100, 64'd4);
      wait_until_drained();

      write_object_length(random_offset());
      quiet_phase = 1'b1;
      queue_random_phase(400, OFFSET_MAX);
      wait_until_drained();

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
